>>> rtl/stq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stq_pkg: sorted timer queue shared definitions
// sizes, entry layout, operation and status codes and sequencer states
// ----------------------------------------------------------------------------
package stq_pkg;

   localparam int DEPTH   = 16;
   localparam int IDX_W   = $clog2(DEPTH);
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int COUNT_W = 5;
   localparam int ID_W    = 16;
   localparam int TIME_W  = 32;

   typedef struct packed {
      logic [ID_W-1:0]          ent_id;
      logic signed [TIME_W-1:0] ent_time;
   } entry_type;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_CANCEL = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      STS_DONE     = 2'd0,
      STS_DUP      = 2'd1,
      STS_NOTFOUND = 2'd2,
      STS_FULL     = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_SCAN,
      ST_SH_FETCH,
      ST_SH_WRITE,
      ST_PUT,
      ST_HEAD,
      ST_RESP
   } state_type;

endpackage : stq_pkg
`default_nettype wire

>>> rtl/sorted_timer_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_timer_queue: time-ordered timer entry store
//
//   channel   ports                      transfer
//   request   start, busy, req_*         start high while busy low
//   response  rsp_strobe, rsp_*          one cycle per strobe, no back-pressure
//
// One sequencer walks the entry RAM and compares one entry at a time: a scan
// visits the entries in order, each with a read step and a compare step, and an
// insert or cancel then shifts the later entries one place, each moved entry
// with a read step and a write step. Reset clears the entry count and returns
// the sequencer to idle; the RAM is not cleared. busy stays high until the
// response strobe has been given.
// ----------------------------------------------------------------------------
module sorted_timer_queue (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          start,
   output logic                         busy,
   input  wire                          req_operation,
   input  wire  [stq_pkg::ID_W-1:0]     req_timer_id,
   input  wire  signed [stq_pkg::TIME_W-1:0] req_expire_time,
   output logic                         rsp_strobe,
   output logic [1:0]                   rsp_status,
   output logic [stq_pkg::COUNT_W-1:0]  rsp_entry_count,
   output logic                         rsp_head_valid,
   output logic [stq_pkg::ID_W-1:0]     rsp_head_id,
   output logic signed [stq_pkg::TIME_W-1:0] rsp_head_time,
   output logic                         rsp_head_expired
);
   import stq_pkg::*;

   state_type   state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [IDX_W-1:0] pos_ff, pos_in;
   logic [CNT_W-1:0] count_ff, count_in;
   op_type      op_ff, op_in;
   logic [ID_W-1:0] id_ff, id_in;
   logic signed [TIME_W-1:0] time_ff, time_in;
   status_type  status_ff, status_in;
   entry_type   rd_ff;
   entry_type   mem [DEPTH];

   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   entry_type        wr_data;
   logic             last_idx;
   logic             accept;

   assign accept   = start && (state_ff == ST_IDLE);
   assign last_idx = ((CNT_W'(idx_ff) + CNT_W'(1)) == count_ff);

   // entry ram
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff <= mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      idx_ff    <= idx_in;
      pos_ff    <= pos_in;
      op_ff     <= op_in;
      id_ff     <= id_in;
      time_ff   <= time_in;
      status_ff <= status_in;
   end

   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      pos_in    = pos_ff;
      count_in  = count_ff;
      op_in     = op_ff;
      id_in     = id_ff;
      time_in   = time_ff;
      status_in = status_ff;
      wr_en     = 1'b0;
      wr_addr   = idx_ff;
      wr_data   = rd_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in     = op_type'(req_operation);
               id_in     = req_timer_id;
               time_in   = req_expire_time;
               status_in = STS_DONE;
               idx_in    = '0;
               pos_in    = '0;
               if (op_type'(req_operation) == OP_INSERT) begin
                  if (count_ff == CNT_W'(DEPTH)) begin
                     status_in = STS_FULL;
                     state_in  = ST_HEAD;
                  end else if (count_ff == '0) begin
                     state_in = ST_PUT;
                  end else begin
                     state_in = ST_FETCH;
                  end
               end else begin
                  if (count_ff == '0) begin
                     status_in = STS_NOTFOUND;
                     state_in  = ST_HEAD;
                  end else begin
                     state_in = ST_FETCH;
                  end
               end
            end
         end
         ST_FETCH: begin
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (op_ff == OP_INSERT) begin
               if (rd_ff.ent_time == time_ff) begin
                  status_in = STS_DUP;
                  idx_in    = '0;
                  state_in  = ST_HEAD;
               end else if (rd_ff.ent_time > time_ff) begin
                  pos_in   = idx_ff;
                  idx_in   = IDX_W'(count_ff - CNT_W'(1));
                  state_in = ST_SH_FETCH;
               end else if (last_idx) begin
                  pos_in   = IDX_W'(count_ff);
                  state_in = ST_PUT;
               end else begin
                  idx_in   = idx_ff + IDX_W'(1);
                  state_in = ST_FETCH;
               end
            end else begin
               if (rd_ff.ent_id == id_ff) begin
                  if (last_idx) begin
                     count_in = count_ff - CNT_W'(1);
                     idx_in   = '0;
                     state_in = ST_HEAD;
                  end else begin
                     idx_in   = idx_ff + IDX_W'(1);
                     state_in = ST_SH_FETCH;
                  end
               end else if (last_idx) begin
                  status_in = STS_NOTFOUND;
                  idx_in    = '0;
                  state_in  = ST_HEAD;
               end else begin
                  idx_in   = idx_ff + IDX_W'(1);
                  state_in = ST_FETCH;
               end
            end
         end
         ST_SH_FETCH: begin
            state_in = ST_SH_WRITE;
         end
         ST_SH_WRITE: begin
            wr_en = 1'b1;
            if (op_ff == OP_INSERT) begin
               wr_addr = idx_ff + IDX_W'(1);
               if (idx_ff == pos_ff) begin
                  state_in = ST_PUT;
               end else begin
                  idx_in   = idx_ff - IDX_W'(1);
                  state_in = ST_SH_FETCH;
               end
            end else begin
               wr_addr = idx_ff - IDX_W'(1);
               if (last_idx) begin
                  count_in = count_ff - CNT_W'(1);
                  idx_in   = '0;
                  state_in = ST_HEAD;
               end else begin
                  idx_in   = idx_ff + IDX_W'(1);
                  state_in = ST_SH_FETCH;
               end
            end
         end
         ST_PUT: begin
            wr_en            = 1'b1;
            wr_addr          = pos_ff;
            wr_data.ent_id   = id_ff;
            wr_data.ent_time = time_ff;
            count_in         = count_ff + CNT_W'(1);
            idx_in           = '0;
            state_in         = ST_HEAD;
         end
         ST_HEAD: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // response fields, head taken from entry zero
   always_comb begin
      busy             = (state_ff != ST_IDLE);
      rsp_strobe       = (state_ff == ST_RESP);
      rsp_status       = status_ff;
      rsp_entry_count  = COUNT_W'(count_ff);
      rsp_head_valid   = (count_ff != '0);
      rsp_head_id      = '0;
      rsp_head_time    = '0;
      rsp_head_expired = 1'b0;
      if (count_ff != '0) begin
         rsp_head_id      = rd_ff.ent_id;
         rsp_head_time    = rd_ff.ent_time;
         rsp_head_expired = rd_ff.ent_time[TIME_W-1] || (rd_ff.ent_time == '0);
      end
   end

endmodule : sorted_timer_queue
`default_nettype wire
